// ===== rtl/core/mvl_pkg.sv =====
`default_nettype none

package mvl_pkg;

  // fixed field widths
  localparam int unsigned CfgW       = 9;
  localparam int unsigned ShiftW     = 5;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned WeightW    = 8;
  localparam int unsigned AccW       = 32;
  localparam int unsigned ProdW      = SampleW + WeightW;
  localparam int unsigned SatBits    = 15 + 4;
  localparam int unsigned RowW       = 8;
  localparam int unsigned MaxRows    = 256;
  localparam int unsigned MaxLengthDefault = 256;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgVectorLength = 2'd0,
    CfgRowCount     = 2'd1,
    CfgBiasShift    = 2'd2,
    CfgResultShift  = 2'd3
  } mvl_cfg_idx_e;

  // input commands
  localparam logic CmdVector = 1'b0;
  localparam logic CmdWeight = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SampleW-1:0]  sample;
    logic signed [WeightW-1:0]  weight;
    logic signed [WeightW-1:0]  bias;
  } mvl_in_t;

  typedef struct packed {
    logic signed [SatBits-1:0]  neuron_out;
    logic [RowW-1:0]            row_index;
    logic                       last;
  } mvl_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/mvl_vector_store.sv =====
`default_nettype none

module mvl_vector_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/int8_int16_matrix_vector_layer_core.sv =====
`default_nettype none

// Fully connected layer engine. Vector transfers (cmd 0) load the input vector into an
// on-chip store in order, wrapping after vector_length elements. Weight transfers (cmd 1)
// then stream the matrix row-major; the first weight of each row also carries the row bias,
// which is shifted left by bias_shift to seed a 32-bit wrapping accumulator. Each weight is
// multiplied by the stored element of its column. After the last column the accumulator is
// shifted right arithmetically by result_shift, saturated to 19-bit signed and sent out with
// its row index and a last flag on the final row. Only weight transfers that close a row
// produce a result. Rate: one transfer per cycle as long as the output side is not stalled;
// a row result passes through the store read, multiply, accumulate and shift-and-saturate
// registers in that order. A stalled output freezes the whole pipeline and stalls the input.
// The user must write configuration only while the engine is idle; the block does not enforce
// it. Reading a store entry that was never loaded gives an undefined result.
module int8_int16_matrix_vector_layer_core #(
  parameter int unsigned MAX_LENGTH = mvl_pkg::MaxLengthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write port
  input  wire logic                       cfg_we_i,
  input  wire mvl_pkg::mvl_cfg_idx_e      cfg_index_i,
  input  wire logic [mvl_pkg::CfgW-1:0]   cfg_data_i,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire mvl_pkg::mvl_in_t           in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output mvl_pkg::mvl_out_t               out_data_o
);

  import mvl_pkg::*;

  localparam int unsigned AddrW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LenW  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CmpW  = (LenW > CfgW) ? LenW : CfgW;

  // per-item tag that follows a weight down the pipe
  typedef struct packed {
    logic                      first;
    logic                      row_end;
    logic                      last;
    logic [RowW-1:0]           row;
    logic signed [WeightW-1:0] weight;
    logic signed [WeightW-1:0] bias;
  } tag_t;

  // configuration registers
  logic [CfgW-1:0]   vector_length_q;
  logic [CfgW-1:0]   row_count_q;
  logic [ShiftW-1:0] bias_shift_q;
  logic [ShiftW-1:0] result_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= CfgW'(1);
      row_count_q     <= CfgW'(1);
      bias_shift_q    <= '0;
      result_shift_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgVectorLength: vector_length_q <= cfg_data_i;
        CfgRowCount:     row_count_q     <= cfg_data_i;
        CfgBiasShift:    bias_shift_q    <= cfg_data_i[ShiftW-1:0];
        CfgResultShift:  result_shift_q  <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths, clamped to legal ranges
  logic [CmpW-1:0] vl_ext;
  logic [LenW-1:0] len_eff;
  logic [CfgW-1:0] rows_eff;

  assign vl_ext = CmpW'(vector_length_q);

  always_comb begin
    if (vl_ext == '0) begin
      len_eff = LenW'(1);
    end else if (vl_ext > CmpW'(MAX_LENGTH)) begin
      len_eff = LenW'(MAX_LENGTH);
    end else begin
      len_eff = LenW'(vl_ext);
    end
    if (row_count_q == '0) begin
      rows_eff = CfgW'(1);
    end else if (row_count_q > CfgW'(MaxRows)) begin
      rows_eff = CfgW'(MaxRows);
    end else begin
      rows_eff = row_count_q;
    end
  end

  // pipeline advance: everything moves unless a result is held by a stalled sink
  logic advance;
  logic in_accept;
  logic out_valid_q;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  // position counters
  logic [AddrW-1:0] load_q, load_d;
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] load_pos, col_pos;
  logic [LenW-1:0]  load_inc, col_inc;
  logic             is_vector, is_weight;
  logic             col_end, row_last;

  assign is_vector = in_accept && (in_data_i.cmd == CmdVector);
  assign is_weight = in_accept && (in_data_i.cmd == CmdWeight);

  always_comb begin
    // a position past a shortened length restarts at zero
    load_pos = (LenW'(load_q) >= len_eff) ? '0 : load_q;
    col_pos  = (LenW'(col_q) >= len_eff) ? '0 : col_q;
    load_inc = LenW'(load_pos) + LenW'(1);
    col_inc  = LenW'(col_pos) + LenW'(1);
    col_end  = (col_inc >= len_eff);
    row_last = ((CfgW'(row_q) + CfgW'(1)) >= rows_eff);

    load_d = load_q;
    col_d  = col_q;
    row_d  = row_q;
    if (is_vector) begin
      load_d = (load_inc >= len_eff) ? '0 : AddrW'(load_inc);
    end
    if (is_weight) begin
      col_d = col_end ? '0 : AddrW'(col_inc);
      if (col_end) begin
        row_d = row_last ? '0 : row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      load_q <= load_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  // vector store: written by vector transfers, read by weight transfers
  logic [SampleW-1:0] rd_data;

  mvl_vector_store #(
    .Depth (MAX_LENGTH),
    .AddrW (AddrW),
    .DataW (SampleW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (is_vector),
    .wr_addr_i (load_pos),
    .wr_data_i (in_data_i.sample),
    .rd_en_i   (is_weight),
    .rd_addr_i (col_pos),
    .rd_data_o (rd_data)
  );

  // stage 1: store read in flight
  logic s1_valid_q;
  tag_t s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= is_weight;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_weight) begin
      s1_tag_q.first   <= (col_pos == '0);
      s1_tag_q.row_end <= col_end;
      s1_tag_q.last    <= row_last;
      s1_tag_q.row     <= row_q;
      s1_tag_q.weight  <= in_data_i.weight;
      s1_tag_q.bias    <= in_data_i.bias;
    end
  end

  // stage 2: product registered
  logic                    s2_valid_q;
  tag_t                    s2_tag_q;
  logic signed [ProdW-1:0] prod_d, prod_q;

  assign prod_d = ProdW'(s1_tag_q.weight) * ProdW'($signed(rd_data));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      s2_tag_q <= s1_tag_q;
      prod_q   <= prod_d;
    end
  end

  // stage 3: accumulate, bias seeds the first column of a row
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] bias_seed;
  logic            s3_valid_q;
  logic [RowW-1:0] s3_row_q;
  logic            s3_last_q;

  assign bias_seed = {{(AccW - WeightW){s2_tag_q.bias[WeightW-1]}}, s2_tag_q.bias}
                     << bias_shift_q;

  always_comb begin
    acc_d = s2_tag_q.first ? bias_seed : acc_q;
    acc_d = acc_d + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q && s2_tag_q.row_end;
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      s3_row_q  <= s2_tag_q.row;
      s3_last_q <= s2_tag_q.last;
    end
  end

  // stage 4: arithmetic right shift and 19-bit saturation into the output register
  logic signed [AccW-1:0]    shifted;
  logic signed [SatBits-1:0] sat_value;
  logic                      fits;
  mvl_out_t                  out_q;

  assign shifted = $signed(acc_q) >>> result_shift_q;
  assign fits    = (&shifted[AccW-1:SatBits-1]) || !(|shifted[AccW-1:SatBits-1]);

  always_comb begin
    if (fits) begin
      sat_value = shifted[SatBits-1:0];
    end else if (shifted[AccW-1]) begin
      sat_value = {1'b1, {(SatBits - 1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(SatBits - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s3_valid_q) begin
      out_q.neuron_out <= sat_value;
      out_q.row_index  <= s3_row_q;
      out_q.last       <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a held result must push back on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while result is held");

  // a new result only comes out of the saturation stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s3_valid_q))
    else $error("result appeared without a finished row");

  // closing the final row returns the row counter to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_weight && col_end && row_last) |=> (row_q == '0))
    else $error("row counter did not wrap after final row");

endmodule

`default_nettype wire
